### src/c2d_pkg.sv
// Shared constants, types and helpers for the streaming 2D convolution block.
package c2d_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_KERNEL = 5;
    localparam int LINE_ROWS  = 2 * MAX_KERNEL;
    localparam int HALF_MAX   = (MAX_KERNEL - 1) / 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int BANK_W     = $clog2(LINE_ROWS);
    localparam int POS_W      = 11;
    localparam int SPOS_W     = POS_W + 2;
    localparam int PIX_W      = 16;
    localparam int TAP_W      = 12;
    localparam int COEFF_W    = 60;
    localparam int PROD_W     = PIX_W + TAP_W;
    localparam int RSUM_W     = PROD_W + 3;
    localparam int SUM_W      = PROD_W + 5;
    localparam int FRAC_SHIFT = 10;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = Q_PTR_W + 1;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;

    // Register indexes, one per 8-byte slot
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_WIDTH   = 3'd0;
    localparam t_reg_idx REG_HEIGHT  = 3'd1;
    localparam t_reg_idx REG_HALF    = 3'd2;
    localparam t_reg_idx REG_COEFF_A = 3'd3;
    localparam t_reg_idx REG_COEFF_B = 3'd4;
    localparam t_reg_idx REG_COEFF_C = 3'd5;
    localparam t_reg_idx REG_COEFF_D = 3'd6;
    localparam t_reg_idx REG_COEFF_E = 3'd7;

    typedef logic [MAX_KERNEL-1:0][PIX_W-1:0]   t_column;
    typedef logic [MAX_KERNEL-1:0]              t_kmask;
    typedef logic [MAX_KERNEL-1:0][COEFF_W-1:0] t_coeffs;

    typedef struct packed {
        logic [POS_W-1:0] width;
        logic [POS_W-1:0] height;
        logic [1:0]       half;
    } t_geom;

    typedef struct packed {
        t_column    col;
        t_kmask     row_ok;
        t_kmask     col_ok;
        logic [1:0] half;
        logic       emit;
        logic       last;
    } t_q_entry;

    // Line-store bank holding kernel row ki for the row stored in bank rowmod
    function automatic logic [BANK_W-1:0] bank_of(logic [BANK_W-1:0] rowmod,
                                                  logic [1:0] half, int ki);
        logic [BANK_W+1:0] s;
        s = (BANK_W+2)'(rowmod) + (BANK_W+2)'(LINE_ROWS)
            - (BANK_W+2)'({half, 1'b0}) + (BANK_W+2)'(ki);
        if (s >= (BANK_W+2)'(LINE_ROWS)) begin
            s = s - (BANK_W+2)'(LINE_ROWS);
        end
        return s[BANK_W-1:0];
    endfunction

endpackage

### src/conv2d_zero_pad_stream.sv
// Streaming zero-padded 2D correlation, kernel up to 5x5: top level and registers.
// Data path: front register, queue, product, row-sum and output registers.
// Throughput: one item per cycle when neither the queue nor the output stalls.
// Reset: synchronous, active low; clears position, queue and pipeline valids,
// restores register defaults; the line store is not cleared.
module conv2d_zero_pad_stream (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [c2d_pkg::ADDR_W-1:0]         paddr,
    input  logic [c2d_pkg::DATA_W-1:0]         pwdata,
    output logic [c2d_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_kind,
    input  logic signed [c2d_pkg::PIX_W-1:0]   i_pixel_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [c2d_pkg::PIX_W-1:0]   o_out_pixel,
    output logic                               o_saturated,
    output logic                               o_frame_last
);

    logic [c2d_pkg::POS_W-1:0] r_width, r_height;
    logic [1:0]                r_half;
    c2d_pkg::t_coeffs          r_coeffs;

    c2d_pkg::t_reg_idx  idx;
    logic               wr;
    c2d_pkg::t_geom     geom;
    logic               push, q_full, pop, q_empty;
    c2d_pkg::t_q_entry  q_in, q_out;

    assign pready = 1'b1;
    assign idx    = paddr[c2d_pkg::ADDR_W-1:3];
    assign wr     = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= c2d_pkg::POS_W'(1024);
            r_height <= c2d_pkg::POS_W'(1024);
            r_half   <= 2'd1;
            r_coeffs <= '0;
        end else if (wr) begin
            case (idx)
                c2d_pkg::REG_WIDTH:   r_width     <= pwdata[c2d_pkg::POS_W-1:0];
                c2d_pkg::REG_HEIGHT:  r_height    <= pwdata[c2d_pkg::POS_W-1:0];
                c2d_pkg::REG_HALF:    r_half      <= pwdata[1:0];
                c2d_pkg::REG_COEFF_A: r_coeffs[0] <= pwdata[c2d_pkg::COEFF_W-1:0];
                c2d_pkg::REG_COEFF_B: r_coeffs[1] <= pwdata[c2d_pkg::COEFF_W-1:0];
                c2d_pkg::REG_COEFF_C: r_coeffs[2] <= pwdata[c2d_pkg::COEFF_W-1:0];
                c2d_pkg::REG_COEFF_D: r_coeffs[3] <= pwdata[c2d_pkg::COEFF_W-1:0];
                c2d_pkg::REG_COEFF_E: r_coeffs[4] <= pwdata[c2d_pkg::COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (idx)
            c2d_pkg::REG_WIDTH:   prdata = c2d_pkg::DATA_W'(r_width);
            c2d_pkg::REG_HEIGHT:  prdata = c2d_pkg::DATA_W'(r_height);
            c2d_pkg::REG_HALF:    prdata = c2d_pkg::DATA_W'(r_half);
            c2d_pkg::REG_COEFF_A: prdata = c2d_pkg::DATA_W'(r_coeffs[0]);
            c2d_pkg::REG_COEFF_B: prdata = c2d_pkg::DATA_W'(r_coeffs[1]);
            c2d_pkg::REG_COEFF_C: prdata = c2d_pkg::DATA_W'(r_coeffs[2]);
            c2d_pkg::REG_COEFF_D: prdata = c2d_pkg::DATA_W'(r_coeffs[3]);
            c2d_pkg::REG_COEFF_E: prdata = c2d_pkg::DATA_W'(r_coeffs[4]);
            default:              prdata = '0;
        endcase
    end

    // Clamp the geometry to its working range
    always_comb begin
        if (r_width == '0) begin
            geom.width = c2d_pkg::POS_W'(1);
        end else if (r_width > c2d_pkg::POS_W'(c2d_pkg::MAX_WIDTH)) begin
            geom.width = c2d_pkg::POS_W'(c2d_pkg::MAX_WIDTH);
        end else begin
            geom.width = r_width;
        end
        geom.height = (r_height == '0) ? c2d_pkg::POS_W'(1) : r_height;
        geom.half   = (r_half > 2'(c2d_pkg::HALF_MAX)) ? 2'(c2d_pkg::HALF_MAX) : r_half;
    end

    c2d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_geom        (geom),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_pixel_value (i_pixel_value),
        .o_push        (push),
        .o_entry       (q_in),
        .i_q_full      (q_full)
    );

    c2d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    c2d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coeffs     (r_coeffs),
        .i_entry      (q_out),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_pixel  (o_out_pixel),
        .o_saturated  (o_saturated),
        .o_frame_last (o_frame_last)
    );

endmodule

### src/c2d_line_store.sv
// Banked line store: one bank per buffered row, all banks read at one column.
module c2d_line_store (
    input  logic                                                   i_clk,
    input  logic                                                   i_wr_en,
    input  logic [c2d_pkg::BANK_W-1:0]                             i_wr_bank,
    input  logic [c2d_pkg::PIX_W-1:0]                              i_wr_data,
    input  logic                                                   i_rd_en,
    input  logic [c2d_pkg::COL_W-1:0]                              i_addr,
    output logic [c2d_pkg::LINE_ROWS-1:0][c2d_pkg::PIX_W-1:0]      o_rd_data
);

    for (genvar g = 0; g < c2d_pkg::LINE_ROWS; g++) begin : g_bank
        logic [c2d_pkg::PIX_W-1:0] r_mem [c2d_pkg::MAX_WIDTH];
        logic [c2d_pkg::PIX_W-1:0] r_rd;

        // Write one pixel, read the column (old data on a same-address write)
        always_ff @(posedge i_clk) begin
            if (i_wr_en && (i_wr_bank == c2d_pkg::BANK_W'(g))) begin
                r_mem[i_addr] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_rd <= r_mem[i_addr];
            end
        end

        assign o_rd_data[g] = r_rd;
    end

endmodule

### src/c2d_front.sv
// Front end: raster position tracking, item classification and column fetch.
module c2d_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  c2d_pkg::t_geom                    i_geom,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_kind,
    input  logic signed [c2d_pkg::PIX_W-1:0]  i_pixel_value,
    output logic                              o_push,
    output c2d_pkg::t_q_entry                 o_entry,
    input  logic                              i_q_full
);

    typedef struct packed {
        logic [c2d_pkg::BANK_W-1:0] rowmod;
        logic [1:0]                 half;
        logic                       wrote;
        logic [c2d_pkg::PIX_W-1:0]  fwd;
        c2d_pkg::t_kmask            row_ok;
        c2d_pkg::t_kmask            col_ok;
        logic                       emit;
        logic                       last;
    } t_b_desc;

    logic [c2d_pkg::POS_W-1:0]  r_col, r_row;
    logic [c2d_pkg::BANK_W-1:0] r_rowmod;
    logic                       r_b_valid;
    t_b_desc                    r_b;

    logic                       accept;
    logic [c2d_pkg::POS_W-1:0]  col1, row1, col2, row2;
    logic [c2d_pkg::BANK_W-1:0] mod1, mod2;
    logic signed [c2d_pkg::SPOS_W-1:0] s_w, s_hgt, s_h, s_row, s_col;
    logic signed [c2d_pkg::SPOS_W-1:0] orow, ocol, rr, cc;
    logic                       wrap, restart, emit, last, wr_en;
    c2d_pkg::t_kmask            row_ok, col_ok;
    t_b_desc                    desc;
    logic [c2d_pkg::LINE_ROWS-1:0][c2d_pkg::PIX_W-1:0] rd_data;
    logic [c2d_pkg::PIX_W-1:0]  wr_data;

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_b_valid || !i_q_full;
    assign o_push  = r_b_valid && !i_q_full;
    assign wr_data = i_kind ? '0 : i_pixel_value;

    // Classify the item: position, output coordinates, masks
    always_comb begin
        col1 = r_col;
        row1 = r_row;
        mod1 = r_rowmod;
        if (r_col >= i_geom.width) begin
            col1 = '0;
            row1 = r_row + 1'b1;
            mod1 = (r_rowmod == c2d_pkg::BANK_W'(c2d_pkg::LINE_ROWS - 1)) ? '0
                                                                         : r_rowmod + 1'b1;
        end
        s_w   = signed'(c2d_pkg::SPOS_W'(i_geom.width));
        s_hgt = signed'(c2d_pkg::SPOS_W'(i_geom.height));
        s_h   = signed'(c2d_pkg::SPOS_W'(i_geom.half));
        s_row = signed'(c2d_pkg::SPOS_W'(row1));
        s_col = signed'(c2d_pkg::SPOS_W'(col1));
        wrap  = col1 < c2d_pkg::POS_W'(i_geom.half);
        if (wrap && ((s_col + s_w) < s_h)) begin
            // Row shorter than the half kernel: the output lies two rows back
            orow = s_row - s_h - c2d_pkg::SPOS_W'(2);
            ocol = s_col + s_w + s_w - s_h;
        end else if (wrap) begin
            orow = s_row - s_h - c2d_pkg::SPOS_W'(1);
            ocol = s_col + s_w - s_h;
        end else begin
            orow = s_row - s_h;
            ocol = s_col - s_h;
        end
        restart = (orow >= s_hgt);
        if (restart) begin
            col2 = '0;
            row2 = '0;
            mod2 = '0;
            // Frame start: only a 1x1 kernel releases an output here
            orow = (i_geom.half == 2'd0) ? '0 : '1;
            ocol = '0;
        end else begin
            col2 = col1;
            row2 = row1;
            mod2 = mod1;
        end
        emit  = !orow[c2d_pkg::SPOS_W-1];
        last  = emit && (orow == s_hgt - c2d_pkg::SPOS_W'(1))
                     && (ocol == s_w - c2d_pkg::SPOS_W'(1));
        wr_en = accept && (row2 < i_geom.height);
        rr    = '0;
        cc    = '0;
        for (int k = 0; k < c2d_pkg::MAX_KERNEL; k++) begin
            rr = orow - s_h + c2d_pkg::SPOS_W'(k);
            cc = ocol - s_h + c2d_pkg::SPOS_W'(k);
            row_ok[k] = (k <= 2 * int'(i_geom.half)) && !rr[c2d_pkg::SPOS_W-1] && (rr < s_hgt);
            col_ok[k] = (k <= 2 * int'(i_geom.half)) && !cc[c2d_pkg::SPOS_W-1] && (cc < s_w);
        end
        desc.rowmod = mod2;
        desc.half   = i_geom.half;
        desc.wrote  = row2 < i_geom.height;
        desc.fwd    = wr_data;
        desc.row_ok = row_ok;
        desc.col_ok = col_ok;
        desc.emit   = emit;
        desc.last   = last;
    end

    // Advance the raster position on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_rowmod <= '0;
        end else if (accept) begin
            if (last) begin
                r_col    <= '0;
                r_row    <= '0;
                r_rowmod <= '0;
            end else begin
                r_col    <= col2 + 1'b1;
                r_row    <= row2;
                r_rowmod <= mod2;
            end
        end
    end

    // Hold the classified item while its column is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (accept) begin
            r_b_valid <= 1'b1;
        end else if (o_push) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b <= desc;
        end
    end

    c2d_line_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_bank (mod2),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_addr    (col2[c2d_pkg::COL_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Gather the column, newest pixel taken from the write path
    always_comb begin
        for (int ki = 0; ki < c2d_pkg::MAX_KERNEL; ki++) begin
            if (ki > 2 * int'(r_b.half)) begin
                o_entry.col[ki] = '0;
            end else if ((ki == 2 * int'(r_b.half)) && r_b.wrote) begin
                o_entry.col[ki] = r_b.fwd;
            end else begin
                o_entry.col[ki] = rd_data[c2d_pkg::bank_of(r_b.rowmod, r_b.half, ki)];
            end
        end
        o_entry.row_ok = r_b.row_ok;
        o_entry.col_ok = r_b.col_ok;
        o_entry.half   = r_b.half;
        o_entry.emit   = r_b.emit;
        o_entry.last   = r_b.last;
    end

endmodule

### src/c2d_fifo.sv
// Short queue between the front end and the arithmetic back end.
module c2d_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  c2d_pkg::t_q_entry i_data,
    output logic              o_full,
    input  logic              i_pop,
    output c2d_pkg::t_q_entry o_data,
    output logic              o_empty
);

    c2d_pkg::t_q_entry             r_mem [c2d_pkg::Q_DEPTH];
    logic [c2d_pkg::Q_PTR_W-1:0]   r_wr, r_rd;
    logic [c2d_pkg::Q_CNT_W-1:0]   r_count;

    assign o_full  = (r_count == c2d_pkg::Q_CNT_W'(c2d_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= c2d_pkg::Q_CNT_W'(c2d_pkg::Q_DEPTH))
        else $error("queue fill level beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push lost");

endmodule

### src/c2d_back.sv
// Back end: column history window, multiply-add tree, rounding and output register.
module c2d_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  c2d_pkg::t_coeffs                  i_coeffs,
    input  c2d_pkg::t_q_entry                 i_entry,
    input  logic                              i_q_empty,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [c2d_pkg::PIX_W-1:0]  o_out_pixel,
    output logic                              o_saturated,
    output logic                              o_frame_last
);

    c2d_pkg::t_column r_hist [c2d_pkg::MAX_KERNEL-1];
    logic signed [c2d_pkg::PROD_W-1:0] r_prod [c2d_pkg::MAX_KERNEL][c2d_pkg::MAX_KERNEL];
    logic signed [c2d_pkg::PROD_W-1:0] n_prod [c2d_pkg::MAX_KERNEL][c2d_pkg::MAX_KERNEL];
    logic signed [c2d_pkg::RSUM_W-1:0] r_rsum [c2d_pkg::MAX_KERNEL];
    logic signed [c2d_pkg::RSUM_W-1:0] n_rsum [c2d_pkg::MAX_KERNEL];
    logic r_s1_valid, r_s1_last, r_s2_valid, r_s2_last;
    logic r_out_valid, r_out_sat, r_out_last;
    logic signed [c2d_pkg::PIX_W-1:0] r_out_pixel, n_out_pixel;
    logic n_out_sat;

    logic en;
    c2d_pkg::t_column a_col [c2d_pkg::MAX_KERNEL];
    c2d_pkg::t_column wcol;
    logic signed [c2d_pkg::PIX_W-1:0] pix;
    logic signed [c2d_pkg::TAP_W-1:0] tap;
    logic signed [c2d_pkg::SUM_W-1:0] total, q;

    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_q_empty;

    assign o_valid      = r_out_valid;
    assign o_out_pixel  = r_out_pixel;
    assign o_saturated  = r_out_sat;
    assign o_frame_last = r_out_last;

    // Shift the new column into the history
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hist[0] <= i_entry.col;
            for (int a = 1; a < c2d_pkg::MAX_KERNEL - 1; a++) begin
                r_hist[a] <= r_hist[a-1];
            end
        end
    end

    // Build the masked window and multiply by the taps
    always_comb begin
        a_col[0] = i_entry.col;
        for (int a = 1; a < c2d_pkg::MAX_KERNEL; a++) begin
            a_col[a] = r_hist[a-1];
        end
        wcol = '0;
        pix  = '0;
        tap  = '0;
        for (int kj = 0; kj < c2d_pkg::MAX_KERNEL; kj++) begin
            case (i_entry.half)
                2'd0:    wcol = (kj == 0) ? a_col[0] : '0;
                2'd1:    wcol = (kj <= 2) ? a_col[(kj <= 2) ? (2 - kj) : 0] : '0;
                default: wcol = a_col[c2d_pkg::MAX_KERNEL - 1 - kj];
            endcase
            for (int ki = 0; ki < c2d_pkg::MAX_KERNEL; ki++) begin
                pix = (i_entry.row_ok[ki] && i_entry.col_ok[kj]) ? signed'(wcol[ki]) : '0;
                tap = signed'(i_coeffs[ki][c2d_pkg::TAP_W*kj +: c2d_pkg::TAP_W]);
                n_prod[ki][kj] = pix * tap;
            end
        end
    end

    // Sum each kernel row, rounding offset folded into the first
    always_comb begin
        for (int ki = 0; ki < c2d_pkg::MAX_KERNEL; ki++) begin
            n_rsum[ki] = (ki == 0) ? c2d_pkg::RSUM_W'(1 << (c2d_pkg::FRAC_SHIFT - 1)) : '0;
            for (int kj = 0; kj < c2d_pkg::MAX_KERNEL; kj++) begin
                n_rsum[ki] = n_rsum[ki] + c2d_pkg::RSUM_W'(r_prod[ki][kj]);
            end
        end
    end

    // Add the row sums, drop the fraction, saturate
    always_comb begin
        total = '0;
        for (int ki = 0; ki < c2d_pkg::MAX_KERNEL; ki++) begin
            total = total + c2d_pkg::SUM_W'(r_rsum[ki]);
        end
        q = total >>> c2d_pkg::FRAC_SHIFT;
        n_out_sat = 1'b0;
        n_out_pixel = q[c2d_pkg::PIX_W-1:0];
        if (q > c2d_pkg::SUM_W'(32767)) begin
            n_out_sat   = 1'b1;
            n_out_pixel = 16'sh7FFF;
        end else if (q < -c2d_pkg::SUM_W'(32768)) begin
            n_out_sat   = 1'b1;
            n_out_pixel = 16'sh8000;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod      <= n_prod;
            r_s1_last   <= i_entry.last;
            r_rsum      <= n_rsum;
            r_s2_last   <= r_s1_last;
            r_out_pixel <= n_out_pixel;
            r_out_sat   <= n_out_sat;
            r_out_last  <= r_s2_last;
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= o_pop && i_entry.emit;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

endmodule

### dv/testbench.sv
// Self-checking testbench for the streaming zero-padded 2D convolution block.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 6000;
    localparam int TARGET_ITEMS = 450;

    typedef struct {
        logic [c2d_pkg::PIX_W-1:0] pix;
        bit                        sat;
        bit                        last;
    } t_filtered;

    // Scoreboard: shadow registers, line store and the queue of expected pixels
    class conv_scoreboard;
        int unsigned       img_w, img_h, half;
        logic [c2d_pkg::COEFF_W-1:0] coeff_row[c2d_pkg::MAX_KERNEL];
        logic [c2d_pkg::PIX_W-1:0]   rows_seen[c2d_pkg::LINE_ROWS][c2d_pkg::MAX_WIDTH];
        int unsigned       col, row;
        t_filtered         filtered_q[$];
        int                errors;
        int                results;

        function new();
            img_w = 1024;
            img_h = 1024;
            half = 1;
            foreach (coeff_row[i]) coeff_row[i] = '0;
            col = 0;
            row = 0;
            errors = 0;
            results = 0;
        endfunction

        function void set_reg(c2d_pkg::t_reg_idx idx, logic [c2d_pkg::DATA_W-1:0] v);
            case (idx)
                c2d_pkg::REG_WIDTH:  img_w = v[10:0];
                c2d_pkg::REG_HEIGHT: img_h = v[10:0];
                c2d_pkg::REG_HALF:   half = v[1:0];
                default: coeff_row[idx - c2d_pkg::REG_COEFF_A] = v[c2d_pkg::COEFF_W-1:0];
            endcase
        endfunction

        // Advance the position and compute the filtered pixel this transfer releases
        function void note_input(bit kind, logic [c2d_pkg::PIX_W-1:0] pv);
            int unsigned w, hh, h, off, stop, t, o, r, c;
            int          rr, cc;
            longint      acc, q;
            logic [c2d_pkg::PIX_W-1:0] p;
            logic signed [c2d_pkg::TAP_W-1:0] tp;
            t_filtered   res;
            w = (img_w == 0) ? 1 : (img_w > c2d_pkg::MAX_WIDTH ? c2d_pkg::MAX_WIDTH : img_w);
            hh = (img_h == 0) ? 1 : img_h;
            h = (half > c2d_pkg::HALF_MAX) ? c2d_pkg::HALF_MAX : half;
            if (col >= w) begin
                col = 0;
                row++;
            end
            off = h * w + h;
            stop = off + w * hh;
            t = row * w + col;
            if (t >= stop) begin
                row = 0;
                col = 0;
                t = 0;
            end
            if (row < hh) rows_seen[row % c2d_pkg::LINE_ROWS][col] = kind ? '0 : pv;
            if (t < off) begin
                col++;
                return;
            end
            o = t - off;
            r = o / w;
            c = o % w;
            acc = 0;
            for (int ki = 0; ki < 2 * h + 1; ki++) begin
                for (int kj = 0; kj < 2 * h + 1; kj++) begin
                    rr = int'(r) - int'(h) + ki;
                    cc = int'(c) - int'(h) + kj;
                    p = '0;
                    if (rr >= 0 && rr < int'(hh) && cc >= 0 && cc < int'(w))
                        p = rows_seen[rr % c2d_pkg::LINE_ROWS][cc];
                    tp = coeff_row[ki][c2d_pkg::TAP_W*kj +: c2d_pkg::TAP_W];
                    acc += longint'($signed(p)) * longint'(tp);
                end
            end
            q = (acc + 512) >>> c2d_pkg::FRAC_SHIFT;
            res.sat = 0;
            if (q > 32767) begin
                q = 32767;
                res.sat = 1;
            end
            if (q < -32768) begin
                q = -32768;
                res.sat = 1;
            end
            res.pix = q[c2d_pkg::PIX_W-1:0];
            res.last = (o == w * hh - 1);
            filtered_q.push_back(res);
            if (res.last) begin
                row = 0;
                col = 0;
            end else begin
                col++;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        // Compare one output transfer with the oldest expected pixel
        task check_result(logic [c2d_pkg::PIX_W-1:0] pix, bit sat, bit last);
            t_filtered e;
            results++;
            if (filtered_q.size() == 0) begin
                report($sformatf("unexpected output pix=%h", pix));
                return;
            end
            e = filtered_q.pop_front();
            if (pix !== e.pix)
                report($sformatf("out_pixel %h, expected %h", pix, e.pix));
            if (sat !== e.sat)
                report($sformatf("saturated %b, expected %b", sat, e.sat));
            if (last !== e.last)
                report($sformatf("frame_last %b, expected %b", last, e.last));
        endtask
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             psel, penable, pwrite;
    logic [c2d_pkg::ADDR_W-1:0]       paddr;
    logic [c2d_pkg::DATA_W-1:0]       pwdata;
    logic [c2d_pkg::DATA_W-1:0]       prdata;
    logic                             pready;
    logic                             i_valid, o_ready, i_kind;
    logic signed [c2d_pkg::PIX_W-1:0] i_pixel_value;
    logic                             o_valid, i_ready;
    logic signed [c2d_pkg::PIX_W-1:0] o_out_pixel;
    logic                             o_saturated, o_frame_last;

    conv2d_zero_pad_stream uut (.*);

    conv_scoreboard sb;
    int sent;
    int frames;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        i_valid = 0;
        i_kind = 0;
        i_pixel_value = '0;
        i_ready = 0;
        send_idle_pct = 8;
        recv_stall_pct = 76;
        sent = 0;
        frames = 0;
        idle_cycles = 0;
        sb = new();
    end

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // Randomly stall the output side
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Observe both channels and time out when nothing moves
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_input(i_kind, i_pixel_value);
            if (o_valid && i_ready) sb.check_result(o_out_pixel, o_saturated, o_frame_last);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task cfg_write(c2d_pkg::t_reg_idx idx, logic [c2d_pkg::DATA_W-1:0] v);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 3'b000};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // Hold one transfer until accepted; idle before it at the current rate
    task send_item(bit kind, logic [c2d_pkg::PIX_W-1:0] pv);
        if (send_idle_pct > 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_valid <= 0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1;
        i_kind <= kind;
        i_pixel_value <= pv;
        do @(posedge i_clk); while (!o_ready);
        sent++;
        if (sent == TARGET_ITEMS / 3) begin
            send_idle_pct = 76;
            recv_stall_pct = 8;
        end else if (sent == 2 * TARGET_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end
    endtask

    function automatic logic [c2d_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return c2d_pkg::PIX_W'($urandom_range(511)) - 16'd256;
            default: return c2d_pkg::PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [c2d_pkg::DATA_W-1:0] rand_coeff_row();
        logic [c2d_pkg::DATA_W-1:0] v;
        v = {$urandom, $urandom};
        for (int j = 0; j < c2d_pkg::MAX_KERNEL; j++) begin
            case ($urandom_range(9))
                0: v[c2d_pkg::TAP_W*j +: c2d_pkg::TAP_W] = 12'h7FF;
                1: v[c2d_pkg::TAP_W*j +: c2d_pkg::TAP_W] = 12'h800;
                2, 3, 4, 5: v[c2d_pkg::TAP_W*j +: c2d_pkg::TAP_W] =
                    c2d_pkg::TAP_W'($urandom_range(600)) - 12'd300;
                default: ;
            endcase
        end
        return v;
    endfunction

    // Program geometry and kernel, stream one whole frame plus drain, then wait idle
    task run_frame(int unsigned w, int unsigned hh, int unsigned h,
                   logic [c2d_pkg::DATA_W-1:0] taps, bit fixed_taps,
                   logic [c2d_pkg::PIX_W-1:0] fixed_pix, bit use_fixed);
        int unsigned we, he, he_k, n_drain;
        cfg_write(c2d_pkg::REG_WIDTH, c2d_pkg::DATA_W'(w));
        cfg_write(c2d_pkg::REG_HEIGHT, c2d_pkg::DATA_W'(hh));
        cfg_write(c2d_pkg::REG_HALF, c2d_pkg::DATA_W'(h));
        cfg_write(c2d_pkg::REG_COEFF_A, fixed_taps ? taps : rand_coeff_row());
        cfg_write(c2d_pkg::REG_COEFF_B, fixed_taps ? taps : rand_coeff_row());
        cfg_write(c2d_pkg::REG_COEFF_C, fixed_taps ? taps : rand_coeff_row());
        cfg_write(c2d_pkg::REG_COEFF_D, fixed_taps ? taps : rand_coeff_row());
        cfg_write(c2d_pkg::REG_COEFF_E, fixed_taps ? taps : rand_coeff_row());
        we = (w == 0) ? 1 : (w > c2d_pkg::MAX_WIDTH ? c2d_pkg::MAX_WIDTH : w);
        he = (hh == 0) ? 1 : hh;
        he_k = (h > c2d_pkg::HALF_MAX) ? c2d_pkg::HALF_MAX : h;
        n_drain = he_k * we + he_k;
        for (int unsigned i = 0; i < we * he; i++) begin
            if (use_fixed) send_item(0, (i % 2) ? ~fixed_pix : fixed_pix);
            else send_item($urandom_range(9) == 0, rand_pixel());
        end
        // drain ticks, with some real pixels that the block must ignore
        for (int unsigned i = 0; i < n_drain; i++) begin
            send_item($urandom_range(99) >= 15, rand_pixel());
        end
        i_valid <= 0;
        while (sb.filtered_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        frames++;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: saturating kernels with extreme pixels, out-of-range geometry
        run_frame(3, 3, 1, {5{12'h7FF}}, 1, 16'h7FFF, 1);
        run_frame(0, 0, 3, {5{12'h800}}, 1, 16'h8000, 1);
        run_frame(2, 2, 0, {5{12'h7FF}}, 1, 16'h8000, 1);

        // narrow tall column: single-pixel rows under a 5x5 kernel
        run_frame(1, 24, 2, '0, 0, '0, 0);

        // random small frames until the item budget is spent
        while (sent < TARGET_ITEMS) begin
            run_frame($urandom_range(8), $urandom_range(6), $urandom_range(3), '0, 0, '0, 0);
        end

        $display("Ran %0d frames, %0d input transfers, %0d filtered pixels checked.",
                 frames, sent, sb.results);
        $display("Covered kernel sizes 1x1 to 5x5, clamped geometry and saturation.");
        if (sb.errors == 0 && sb.filtered_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
src/c2d_pkg.sv
src/c2d_line_store.sv
src/c2d_front.sv
src/c2d_fifo.sv
src/c2d_back.sv
src/conv2d_zero_pad_stream.sv
dv/testbench.sv
